// ----- rtl/tprb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tprb_pkg
// Shared types and constants for the transform unit.
// ----------------------------------------------------------------------------
package tprb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int COEF_W          = 32;
  localparam int REG_W           = 64;
  localparam int NUM_REGS        = 8;
  localparam int REG_IDX_W       = 3;
  localparam int CFG_IDX_W       = 8;
  localparam int RAW_W           = 32;

  typedef enum logic [1:0] {
    CMD_POINT  = 2'd0,
    CMD_RAY    = 2'd1,
    CMD_BOUNDS = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WZERO = 2'd1,
    ST_DZERO = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/tprb_divu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tprb_divu
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tprb_divu #(
  parameter int NW = 64,
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo
);
  import tprb_pkg::*;

  logic [NW-1:0] nq  [NW+1];
  logic [DW:0]   rem [NW+1];
  logic [DW-1:0] dd  [NW+1];

  always_comb begin
    nq[0]  = num;
    rem[0] = '0;
    dd[0]  = den;
  end

  // one quotient bit per stage, registered
  for (genvar s = 0; s < NW; s++) begin : g_st
    logic [DW+1:0] tr;
    logic [DW+1:0] df;
    always_comb begin
      tr = {rem[s], nq[s][NW-1]};
      df = tr - {2'b00, dd[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dd[s+1] <= dd[s];
        if (!df[DW+1]) begin
          rem[s+1] <= df[DW:0];
          nq[s+1]  <= {nq[s][NW-2:0], 1'b1};
        end else begin
          rem[s+1] <= tr[DW:0];
          nq[s+1]  <= {nq[s][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = nq[NW];

endmodule
`default_nettype wire

// ----- rtl/transform_point_ray_bounds.sv -----
`default_nettype none
// Pipeline: from the edge that accepts an input word to the edge at which its
//   result word can be taken: six front stages, 32 square root stages,
//   AW+FRAC_BITS (84) divider stages and the output register.
// Throughput: one word per cycle; the whole pipe advances when the output
//   register is empty or being read.
// Reset: rst clears all valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
// transform_point_ray_bounds
// Applies a 4x4 fixed-point matrix to a point, a ray or a bounding box.
// ----------------------------------------------------------------------------
module transform_point_ray_bounds #(
  parameter int COORD_WIDTH = tprb_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tprb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tprb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tprb_pkg::REG_W-1:0]       cfg_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // cmd, a_x, a_y, a_z, b_x, b_y, b_z, ray_limit, ray_time (zero padded)
  input  wire logic [((2+6*COORD_WIDTH+64+7)/8)*8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // res_a_x..z, res_b_x..z, res_limit, res_time, status (zero padded)
  output logic [((6*COORD_WIDTH+66+7)/8)*8-1:0] m_tdata
);
  import tprb_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int PW   = COEF_W + CW + 1;        // one product
  localparam int AW   = PW + 3;                 // sum of four terms
  localparam int OW   = ((6*CW+66+7)/8)*8;
  localparam int DNW  = AW + FB;                // origin numerator
  localparam int SQW  = 64;

  // ---- configuration registers
  logic [REG_W-1:0] regs [NUM_REGS];
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      regs[0] <= 64'd65536;        regs[1] <= '0;
      regs[2] <= 64'd65536 << 32;  regs[3] <= '0;
      regs[4] <= '0;               regs[5] <= 64'd65536;
      regs[6] <= '0;               regs[7] <= 64'd65536 << 32;
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      regs[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  function automatic logic signed [COEF_W-1:0] cf(input logic [REG_W-1:0] r [NUM_REGS],
                                                   input int row, input int col);
    logic [REG_W-1:0] w;
    w = r[row*2 + col/2];
    return (col % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

  // ---- pipe control: the whole pipe moves together
  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---- stage 0: unpack
  logic         v0;
  cmd_t         cmd0;
  logic signed [CW-1:0] a0 [3], b0 [3];
  logic [RAW_W-1:0] lim0, tim0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= s_tvalid;
    if (adv) begin
      cmd0 <= cmd_t'(s_tdata[1:0]);
      for (int i = 0; i < 3; i++) begin
        a0[i] <= s_tdata[2+i*CW +: CW];
        b0[i] <= s_tdata[2+(3+i)*CW +: CW];
      end
      lim0 <= s_tdata[2+6*CW +: RAW_W];
      tim0 <= s_tdata[2+6*CW+RAW_W +: RAW_W];
    end
  end

  // ---- stage 1: all products (one multiplier each, registered)
  // corner k: c[i] = bit i of k ? b : a. Products on a (4 rows x 3 cols) and on
  // b (3x3) are formed; corner k picks each term from them (corner 7 = b products).
  logic         v1;
  cmd_t         cmd1;
  logic [RAW_W-1:0] lim1, tim1;
  logic signed [PW-1:0] pa [4][3];   // row r, col j, on a
  logic signed [PW-1:0] pb [3][3];   // on b
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= v0;
    if (adv) begin
      cmd1 <= cmd0; lim1 <= lim0; tim1 <= tim0;
      for (int r = 0; r < 4; r++)
        for (int j = 0; j < 3; j++)
          pa[r][j] <= PW'(cf(regs, r, j)) * PW'(a0[j]);
      for (int r = 0; r < 3; r++)
        for (int j = 0; j < 3; j++)
          pb[r][j] <= PW'(cf(regs, r, j)) * PW'(b0[j]);
    end
  end

  // ---- stage 2: row sums for eight corners, origin w, direction
  logic         v2;
  cmd_t         cmd2;
  logic [RAW_W-1:0] lim2, tim2;
  logic signed [AW-1:0] cs [8][3];   // corner sums with translation
  logic signed [AW-1:0] ws;          // w of origin
  logic signed [AW-1:0] ds [3];      // direction
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      cmd2 <= cmd1; lim2 <= lim1; tim2 <= tim1;
      for (int k = 0; k < 8; k++)
        for (int r = 0; r < 3; r++)
          cs[k][r] <= AW'(k[0] ? pb[r][0] : pa[r][0]) + AW'(k[1] ? pb[r][1] : pa[r][1])
                    + AW'(k[2] ? pb[r][2] : pa[r][2])
                    + (AW'(cf(regs, r, 3)) <<< FB);
      ws <= AW'(pa[3][0]) + AW'(pa[3][1]) + AW'(pa[3][2]) + (AW'(cf(regs, 3, 3)) <<< FB);
      for (int r = 0; r < 3; r++)
        ds[r] <= AW'(pb[r][0]) + AW'(pb[r][1]) + AW'(pb[r][2]);
    end
  end

  // ---- stage 3: rounding and clamping of corners; origin numerators; magnitudes
  function automatic logic signed [CW-1:0] clampv(input logic signed [AW-1:0] v,
                                                  output logic s);
    logic signed [AW-1:0] hi, lo;
    hi = AW'((AW'(1) <<< (CW-1)) - 1);
    lo = -hi - AW'(1);
    s = 1'b0;
    if (v < lo) begin s = 1'b1; return lo[CW-1:0]; end
    if (v > hi) begin s = 1'b1; return hi[CW-1:0]; end
    return v[CW-1:0];
  endfunction

  logic         v3;
  cmd_t         cmd3;
  logic [RAW_W-1:0] lim3, tim3;
  logic signed [CW-1:0] cr [8][3];
  logic [7:0]   csat;
  logic [DNW-1:0] onum [3];
  logic         oneg [3];
  logic [AW-1:0]  wmag;
  logic         wz3;
  logic [AW-1:0]  dmag [3];
  logic         dneg [3];
  logic         dz3;
  always_ff @(posedge clk) begin
    logic s;
    logic [7:0] cs_t;
    logic signed [AW-1:0] rr;
    logic [AW-1:0] xm;
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      cmd3 <= cmd2; lim3 <= lim2; tim3 <= tim2;
      cs_t = '0;
      for (int k = 0; k < 8; k++)
        for (int r = 0; r < 3; r++) begin
          rr = (cs[k][r] + (AW'(1) <<< (FB-1))) >>> FB;
          cr[k][r] <= clampv(rr, s);
          cs_t[k] = cs_t[k] | s;
        end
      csat <= cs_t;
      wmag <= ws[AW-1] ? AW'(-ws) : AW'(ws);
      wz3  <= (ws == '0);
      for (int r = 0; r < 3; r++) begin
        xm = cs[0][r][AW-1] ? AW'(-cs[0][r]) : AW'(cs[0][r]);
        onum[r] <= DNW'(xm) << FB;
        oneg[r] <= cs[0][r][AW-1] ^ ws[AW-1];
        dmag[r] <= ds[r][AW-1] ? AW'(-ds[r]) : AW'(ds[r]);
        dneg[r] <= ds[r][AW-1];
      end
      dz3 <= (ds[0] == '0) && (ds[1] == '0) && (ds[2] == '0);
    end
  end

  // ---- stage 4: min/max tree over corners; direction normalization shift
  function automatic int lead(input logic [AW-1:0] x);
    int p;
    p = -1;
    for (int i = 0; i < AW; i++) if (x[i]) p = i;
    return p;
  endfunction

  logic         v4;
  cmd_t         cmd4;
  logic [RAW_W-1:0] lim4, tim4;
  logic signed [CW-1:0] bmin [3], bmax [3];
  logic         bsat4;
  logic [DNW-1:0] onum4 [3];
  logic         oneg4 [3];
  logic [AW-1:0]  wmag4;
  logic         wz4, dz4;
  logic [31:0]  dv [3];
  logic         dneg4 [3];
  always_ff @(posedge clk) begin
    logic signed [CW-1:0] mn, mx;
    logic [AW-1:0] m;
    int lp;
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      cmd4 <= cmd3; lim4 <= lim3; tim4 <= tim3;
      for (int r = 0; r < 3; r++) begin
        mn = cr[0][r]; mx = cr[0][r];
        for (int k = 1; k < 8; k++) begin
          if (cr[k][r] < mn) mn = cr[k][r];
          if (cr[k][r] > mx) mx = cr[k][r];
        end
        // a point is corner zero alone
        bmin[r] <= (cmd3 == CMD_POINT) ? cr[0][r] : mn;
        bmax[r] <= mx;
      end
      bsat4 <= (cmd3 == CMD_POINT) ? csat[0] : |csat;
      m = dmag[0] | dmag[1] | dmag[2];
      lp = lead(m);
      for (int r = 0; r < 3; r++) begin
        if (lp > 30) dv[r] <= 32'(dmag[r] >> (lp - 30));
        else if (lp >= 0) dv[r] <= 32'(dmag[r] << (30 - lp));
        else dv[r] <= '0;
        onum4[r] <= onum[r]; oneg4[r] <= oneg[r]; dneg4[r] <= dneg[r];
      end
      wmag4 <= wmag; wz4 <= wz3; dz4 <= dz3;
    end
  end

  // ---- stage 5: sum of squares
  logic         v5;
  cmd_t         cmd5;
  logic [RAW_W-1:0] lim5, tim5;
  logic signed [CW-1:0] bmin5 [3], bmax5 [3];
  logic         bsat5, wz5, dz5;
  logic [DNW-1:0] onum5 [3];
  logic         oneg5 [3];
  logic [AW-1:0]  wmag5;
  logic [31:0]  dv5 [3];
  logic         dneg5 [3];
  logic [SQW-1:0] ssq5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
    if (adv) begin
      cmd5 <= cmd4; lim5 <= lim4; tim5 <= tim4;
      bmin5 <= bmin; bmax5 <= bmax; bsat5 <= bsat4; wz5 <= wz4; dz5 <= dz4;
      onum5 <= onum4; oneg5 <= oneg4; wmag5 <= wmag4; dv5 <= dv; dneg5 <= dneg4;
      ssq5 <= SQW'(dv[0]) * SQW'(dv[0]) + SQW'(dv[1]) * SQW'(dv[1])
            + SQW'(dv[2]) * SQW'(dv[2]);
    end
  end

  // ---- square root: one result bit per stage (32 stages)
  localparam int SQS = 32;
  logic [SQW-1:0] sx [SQS+1];
  logic [31:0]    sr [SQS+1];
  assign sx[0] = ssq5;
  assign sr[0] = '0;
  for (genvar s = 0; s < SQS; s++) begin : g_sq
    logic [31:0] tr;
    assign tr = sr[s] | (32'd1 << (SQS-1-s));
    always_ff @(posedge clk) begin
      if (adv) begin
        if (SQW'(tr) * SQW'(tr) <= sx[s]) sr[s+1] <= tr;
        else sr[s+1] <= sr[s];
        sx[s+1] <= sx[s];
      end
    end
  end

  // delay lane holding the rest of the item during the root
  typedef struct packed {
    logic v; cmd_t cmd; logic [RAW_W-1:0] lim, tim;
    logic bsat, wz, dz;
  } ctl_t;
  ctl_t cq [SQS+1];
  logic [3*CW-1:0] mnq [SQS+1], mxq [SQS+1];
  logic [3*DNW-1:0] onq [SQS+1];
  logic [2:0] onegq [SQS+1], dnegq [SQS+1];
  logic [AW-1:0] wq [SQS+1];
  logic [95:0] dvq [SQS+1];
  assign cq[0]  = '{v5, cmd5, lim5, tim5, bsat5, wz5, dz5};
  assign mnq[0] = {bmin5[2], bmin5[1], bmin5[0]};
  assign mxq[0] = {bmax5[2], bmax5[1], bmax5[0]};
  assign onq[0] = {onum5[2], onum5[1], onum5[0]};
  assign onegq[0] = {oneg5[2], oneg5[1], oneg5[0]};
  assign dnegq[0] = {dneg5[2], dneg5[1], dneg5[0]};
  assign wq[0]  = wmag5;
  assign dvq[0] = {dv5[2], dv5[1], dv5[0]};
  for (genvar s = 0; s < SQS; s++) begin : g_dl
    always_ff @(posedge clk) begin
      if (rst) cq[s+1].v <= 1'b0;
      else if (adv) cq[s+1].v <= cq[s].v;
      if (adv) begin
        cq[s+1].cmd <= cq[s].cmd; cq[s+1].lim <= cq[s].lim; cq[s+1].tim <= cq[s].tim;
        cq[s+1].bsat <= cq[s].bsat; cq[s+1].wz <= cq[s].wz; cq[s+1].dz <= cq[s].dz;
        mnq[s+1] <= mnq[s]; mxq[s+1] <= mxq[s]; onq[s+1] <= onq[s];
        onegq[s+1] <= onegq[s]; dnegq[s+1] <= dnegq[s]; wq[s+1] <= wq[s];
        dvq[s+1] <= dvq[s];
      end
    end
  end

  // ---- divider inputs: origin and direction
  logic [SQW-1:0] nrm;
  assign nrm = SQW'(sr[SQS]);
  logic [DNW-1:0] oq [3];
  logic [DNW-1:0] dq [3];
  for (genvar r = 0; r < 3; r++) begin : g_div
    logic [DNW-1:0] on, dn;
    assign on = onq[SQS][r*DNW +: DNW] + DNW'(wq[SQS] >> 1);
    assign dn = DNW'((SQW'(dvq[SQS][r*32 +: 32]) << FB) + (nrm >> 1));
    tprb_divu #(.NW(DNW), .DW(AW)) u_odiv (
      .clk(clk), .en(adv), .num(on), .den(wq[SQS]), .quo(oq[r]));
    tprb_divu #(.NW(DNW), .DW(SQW)) u_ddiv (
      .clk(clk), .en(adv), .num(dn), .den(nrm), .quo(dq[r]));
  end

  ctl_t dc [DNW+1];
  logic [3*CW-1:0] dmn [DNW+1], dmx [DNW+1];
  logic [2:0] doneg [DNW+1], ddneg [DNW+1];
  assign dc[0] = cq[SQS]; assign dmn[0] = mnq[SQS]; assign dmx[0] = mxq[SQS];
  assign doneg[0] = onegq[SQS]; assign ddneg[0] = dnegq[SQS];
  for (genvar s = 0; s < DNW; s++) begin : g_dd
    always_ff @(posedge clk) begin
      if (rst) dc[s+1].v <= 1'b0;
      else if (adv) dc[s+1].v <= dc[s].v;
      if (adv) begin
        dc[s+1].cmd <= dc[s].cmd; dc[s+1].lim <= dc[s].lim; dc[s+1].tim <= dc[s].tim;
        dc[s+1].bsat <= dc[s].bsat; dc[s+1].wz <= dc[s].wz; dc[s+1].dz <= dc[s].dz;
        dmn[s+1] <= dmn[s]; dmx[s+1] <= dmx[s];
        doneg[s+1] <= doneg[s]; ddneg[s+1] <= ddneg[s];
      end
    end
  end

  // ---- output stage: signs, clamping, status
  function automatic logic signed [CW-1:0] sclamp(input logic [DNW-1:0] q,
                                                  input logic n, output logic s);
    logic signed [DNW+1:0] v;
    logic signed [DNW+1:0] hi, lo;
    v  = n ? -$signed({2'b00, q}) : $signed({2'b00, q});
    hi = (DNW+2)'((DNW+2)'(1) <<< (CW-1)) - 1;
    lo = -hi - 1;
    s = 1'b0;
    if (v < lo) begin s = 1'b1; return lo[CW-1:0]; end
    if (v > hi) begin s = 1'b1; return hi[CW-1:0]; end
    return v[CW-1:0];
  endfunction

  ctl_t fc;
  assign fc = dc[DNW];
  always_ff @(posedge clk) begin
    logic s, st;
    logic signed [CW-1:0] ra [3], rb [3];
    logic [RAW_W-1:0] lo_, ti_;
    status_t sv;
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= fc.v;
    if (adv) begin
      st = 1'b0;
      lo_ = '0; ti_ = '0;
      for (int r = 0; r < 3; r++) begin ra[r] = '0; rb[r] = '0; end
      sv = ST_OK;
      unique case (fc.cmd)
        CMD_POINT: begin
          for (int r = 0; r < 3; r++) ra[r] = dmn[DNW][r*CW +: CW];
          sv = fc.bsat ? ST_SAT : ST_OK;
        end
        CMD_BOUNDS: begin
          for (int r = 0; r < 3; r++) begin
            ra[r] = dmn[DNW][r*CW +: CW];
            rb[r] = dmx[DNW][r*CW +: CW];
          end
          sv = fc.bsat ? ST_SAT : ST_OK;
        end
        CMD_RAY: begin
          lo_ = fc.lim; ti_ = fc.tim;
          if (!fc.wz)
            for (int r = 0; r < 3; r++) begin
              ra[r] = sclamp(oq[r], doneg[DNW][r], s); st = st | s;
            end
          if (!fc.dz)
            for (int r = 0; r < 3; r++) begin
              rb[r] = sclamp(dq[r], ddneg[DNW][r], s); st = st | s;
            end
          sv = fc.wz ? ST_WZERO : fc.dz ? ST_DZERO : st ? ST_SAT : ST_OK;
        end
        default: sv = ST_OK;
      endcase
      m_tdata <= OW'({sv, ti_, lo_, rb[2], rb[1], rb[0], ra[2], ra[1], ra[0]});
    end
  end

`ifndef ASSERT_OFF
  // status never flags for unused command
  a_none: assert property (@(posedge clk) disable iff (rst)
    (adv && fc.v && fc.cmd == CMD_NONE) |=> (m_tdata[6*CW+64 +: 2] == ST_OK))
    else $error("status set for unused command");
  // output holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("result changed under stall");
  // a config write to register 0 lands
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_index == CFG_IDX_W'(0)) |=> (regs[0] == $past(cfg_data)))
    else $error("config write lost");
`endif

endmodule
`default_nettype wire
